// ===== design/fspp_pkg.sv =====
// ============================================================================
// fspp_pkg: shared types and constants of the four-axis step pulse planner
// Item kinds, the queued item, the configuration bundle and fixed widths.
// ============================================================================
package fspp_pkg;

    localparam int NUM_AXES   = 4;
    localparam int POS_W      = 24;  // axis position, 1/2^frac mm, signed
    localparam int SPM_W      = 12;  // steps per millimetre
    localparam int FEED_W     = 16;  // feedrate, mm/min
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 120; // 117 payload bits padded to bytes
    localparam int OUT_DATA_W = 16;  // 11 flag bits padded to bytes
    localparam int RES_W      = 11;
    localparam int DIST_W     = 25;  // path length, one bit above a position delta
    localparam int USEC_W     = 26;
    localparam int DUR_W      = DIST_W + USEC_W;
    localparam int ROOT_IN_W  = 50;  // even width holding the sum of two squares

    localparam logic [FEED_W-1:0] FEED_RESET   = 16'd1500;
    localparam logic [USEC_W-1:0] USEC_PER_MIN = 26'd60000000;

    localparam logic [SPM_W-1:0] SPM_X_RESET = 12'd80;
    localparam logic [SPM_W-1:0] SPM_Y_RESET = 12'd80;
    localparam logic [SPM_W-1:0] SPM_Z_RESET = 12'd400;
    localparam logic [SPM_W-1:0] SPM_E_RESET = 12'd100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPM_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPM_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPM_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPM_E   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORBID  = 3'd4;

    // Request codes on the input tuser.
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MOVE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SETPOS = 2'd2;

    localparam int AXIS_E = 3;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_MOVE,
        KIND_SETPOS,
        KIND_IGNORE
    } fspp_kind_t;

    typedef struct packed {
        fspp_kind_t                       kind;
        logic [NUM_AXES-1:0][POS_W-1:0]   tgt;
        logic [NUM_AXES-1:0]              present;
        logic [FEED_W-1:0]                feed;
        logic                             feed_present;
    } fspp_item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][SPM_W-1:0] spm;
        logic                           forbid_retract;
    } fspp_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQ_GO,
        ST_SQRT,
        ST_DUR_MUL,
        ST_DUR_GO,
        ST_DUR_DIV,
        ST_IV_GO,
        ST_IV_DIV,
        ST_DONE
    } fspp_state_t;

endpackage

// ===== design/fspp_front.sv =====
// ============================================================================
// fspp_front: input side of the planner
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ============================================================================
module fspp_front
    import fspp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [REQ_W-1:0]     in_req,
    input  logic [IN_DATA_W-1:0] in_data,
    output logic                 head_valid,
    output fspp_item_t           head_item,
    input  logic                 pop
);

    fspp_item_t  q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    fspp_item_t  item;
    logic        push;

    always_comb
    begin
        case (in_req)
            REQ_TICK:   item.kind = KIND_TICK;
            REQ_MOVE:   item.kind = KIND_MOVE;
            REQ_SETPOS: item.kind = KIND_SETPOS;
            default:    item.kind = KIND_IGNORE;
        endcase
        for (int i = 0; i < NUM_AXES; i++)
        begin
            item.tgt[i] = in_data[i*POS_W +: POS_W];
        end
        item.present      = in_data[96 +: NUM_AXES];
        item.feed         = in_data[100 +: FEED_W];
        item.feed_present = in_data[116];
    end

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== design/fspp_isqrt.sv =====
// ============================================================================
// fspp_isqrt: iterative integer square root
// Two operand bits per cycle, floor result.
// ============================================================================
module fspp_isqrt #(
    parameter int IN_W = 50
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [IN_W-1:0]     operand,
    output logic                done,
    output logic [IN_W/2-1:0]   root
);

    localparam int ITER  = IN_W / 2;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [IN_W-1:0]  n_reg, n_next;
    logic [IN_W-1:0]  res_reg, res_next;
    logic [IN_W-1:0]  bit_reg, bit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [IN_W-1:0]  trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = operand;
            res_next  = '0;
            bit_next  = {2'b01, {(IN_W-2){1'b0}}};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[IN_W/2-1:0];

endmodule

// ===== design/fspp_div.sv =====
// ============================================================================
// fspp_div: restoring unsigned divider
// One quotient bit per cycle.
// ============================================================================
module fspp_div #(
    parameter int DVD_W = 51,
    parameter int DVS_W = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              done,
    output logic [DVD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits DVS_W bits.
            if (!diff[DVS_W])
            begin
                rem_next = diff[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/fspp_back.sv =====
// ============================================================================
// fspp_back: execution side of the planner
// Runs ticks, set-position and move planning, and holds the result register.
// ============================================================================
module fspp_back
    import fspp_pkg::*;
#(
    parameter int POS_FRAC_BITS  = 8,
    parameter int INTERVAL_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fspp_cfg_t        cfg,
    input  logic             head_valid,
    input  fspp_item_t       head_item,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [RES_W-1:0] res_data
);

    localparam int IW       = INTERVAL_WIDTH;
    localparam int PROD_W   = POS_W + SPM_W;
    localparam int STEP_W   = (PROD_W - POS_FRAC_BITS > 32) ? 32 : PROD_W - POS_FRAC_BITS;
    localparam int FDIV_W   = FEED_W + POS_FRAC_BITS;
    localparam int DVS_W    = (STEP_W > FDIV_W) ? STEP_W : FDIV_W;
    localparam logic [IW-1:0] IV_MAX = '1;

    fspp_state_t state_reg, state_next;

    logic signed [POS_W-1:0] pos_reg   [NUM_AXES];
    logic [STEP_W-1:0]       steps_reg [NUM_AXES];
    logic [IW-1:0]           ival_reg  [NUM_AXES];
    logic [IW-1:0]           elap_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]     dir_reg;
    logic [FEED_W-1:0]       feed_reg;
    logic [1:0]              axis_reg;
    logic                    out_valid_reg;
    logic [RES_W-1:0]        out_data_reg;

    logic [POS_W-1:0]        d_reg  [NUM_AXES];
    logic [2*POS_W-1:0]      sq_reg [2];
    logic [DIST_W-1:0]       dist_reg;
    logic [DUR_W-1:0]        dur_reg;

    logic                    busy, t_busy, out_free;
    logic [IW-1:0]           e_inc   [NUM_AXES];
    logic [IW-1:0]           t_elap  [NUM_AXES];
    logic [STEP_W-1:0]       t_steps [NUM_AXES];
    logic [NUM_AXES-1:0]     stepped;
    logic signed [POS_W-1:0] tgt     [NUM_AXES];
    logic signed [POS_W:0]   diff    [NUM_AXES];
    logic [POS_W-1:0]        d_new   [NUM_AXES];
    logic [NUM_AXES-1:0]     dir_new;
    logic [PROD_W-1:0]       sprod   [NUM_AXES];

    logic                    accept_ok;
    logic                    load_out;
    logic [NUM_AXES-1:0]     r_step;
    logic                    r_moving, r_done, r_rej;
    logic                    sqrt_start, sqrt_done;
    logic [DIST_W-1:0]       root;
    logic                    div_start, div_done;
    logic [DVS_W-1:0]        div_b;
    logic [DUR_W-1:0]        div_q;
    logic [IW-1:0]           iv_sat;
    logic                    steps_zero;

    assign busy      = (steps_reg[0] != '0) || (steps_reg[1] != '0) ||
                       (steps_reg[2] != '0) || (steps_reg[3] != '0);
    assign out_free  = !out_valid_reg || res_ready;
    assign accept_ok = head_valid && out_free;
    assign steps_zero = (steps_reg[axis_reg] == '0);

    // One microsecond of time on every axis that still has steps.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            e_inc[i]   = (elap_reg[i] != IV_MAX) ? elap_reg[i] + 1'b1 : elap_reg[i];
            stepped[i] = 1'b0;
            t_elap[i]  = elap_reg[i];
            t_steps[i] = steps_reg[i];
            if (steps_reg[i] != '0)
            begin
                if (e_inc[i] >= ival_reg[i])
                begin
                    stepped[i] = 1'b1;
                    t_elap[i]  = '0;
                    t_steps[i] = steps_reg[i] - 1'b1;
                end
                else
                begin
                    t_elap[i] = e_inc[i];
                end
            end
        end
        t_busy = (t_steps[0] != '0) || (t_steps[1] != '0) ||
                 (t_steps[2] != '0) || (t_steps[3] != '0);
    end

    // Move targets, deltas and directions.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            tgt[i] = head_item.present[i] ? $signed(head_item.tgt[i]) : pos_reg[i];
        end
        if (cfg.forbid_retract && (tgt[AXIS_E] < pos_reg[AXIS_E]))
        begin
            tgt[AXIS_E] = pos_reg[AXIS_E];
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            diff[i]    = {tgt[i][POS_W-1], tgt[i]} - {pos_reg[i][POS_W-1], pos_reg[i]};
            d_new[i]   = diff[i][POS_W] ? POS_W'(-diff[i]) : POS_W'(diff[i]);
            dir_new[i] = !diff[i][POS_W] && (diff[i] != '0);
            sprod[i]   = PROD_W'(d_reg[i]) * PROD_W'(cfg.spm[i]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_ok && (head_item.kind == KIND_MOVE) && !busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:     state_next = ST_SQ_GO;
            ST_SQ_GO:   state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_DUR_MUL;
                end
            end
            ST_DUR_MUL: state_next = ST_DUR_GO;
            ST_DUR_GO:  state_next = (feed_reg != '0) ? ST_DUR_DIV : ST_IV_GO;
            ST_DUR_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IV_GO;
                end
            end
            ST_IV_GO:
            begin
                if (!steps_zero && (feed_reg != '0))
                begin
                    state_next = ST_IV_DIV;
                end
                else if (axis_reg == 2'(NUM_AXES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_IV_DIV:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == 2'(NUM_AXES - 1)) ? ST_DONE : ST_IV_GO;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        load_out   = 1'b0;
        r_step     = '0;
        r_moving   = busy;
        r_done     = 1'b0;
        r_rej      = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        div_b      = DVS_W'(steps_reg[axis_reg]);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_ok)
                begin
                    pop = 1'b1;
                    case (head_item.kind)
                        KIND_TICK:
                        begin
                            load_out = 1'b1;
                            r_step   = stepped;
                            r_moving = t_busy;
                            r_done   = busy && !t_busy;
                        end
                        KIND_MOVE:
                        begin
                            // An accepted move reports once its plan is complete.
                            load_out = busy;
                            r_rej    = busy;
                        end
                        KIND_SETPOS:
                        begin
                            load_out = 1'b1;
                            r_rej    = busy;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_SQ_GO:   sqrt_start = 1'b1;
            ST_DUR_GO:
            begin
                div_start = (feed_reg != '0);
                div_b     = DVS_W'({feed_reg, {POS_FRAC_BITS{1'b0}}});
            end
            ST_IV_GO:   div_start = !steps_zero && (feed_reg != '0);
            ST_DONE:    load_out  = out_free;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign iv_sat = (div_q > DUR_W'(IV_MAX)) ? IV_MAX : div_q[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            feed_reg      <= FEED_RESET;
            dir_reg       <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_reg[i]   <= '0;
                steps_reg[i] <= '0;
                ival_reg[i]  <= '0;
                elap_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {r_rej, r_done, r_moving, dir_reg, r_step};
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_ok && !busy && (head_item.kind == KIND_MOVE))
                    begin
                        if (head_item.feed_present)
                        begin
                            feed_reg <= head_item.feed;
                        end
                        dir_reg  <= dir_new;
                        axis_reg <= '0;
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            pos_reg[i]  <= tgt[i];
                            elap_reg[i] <= '0;
                        end
                    end
                    else if (accept_ok && !busy && (head_item.kind == KIND_SETPOS))
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            if (head_item.present[i])
                            begin
                                pos_reg[i] <= $signed(head_item.tgt[i]);
                            end
                        end
                    end
                    else if (accept_ok && (head_item.kind == KIND_TICK))
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            steps_reg[i] <= t_steps[i];
                            elap_reg[i]  <= t_elap[i];
                        end
                    end
                end
                ST_MUL:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        steps_reg[i] <= STEP_W'(sprod[i] >> POS_FRAC_BITS);
                    end
                end
                ST_IV_GO:
                begin
                    if (steps_zero)
                    begin
                        ival_reg[axis_reg] <= '0;
                        axis_reg           <= axis_reg + 1'b1;
                    end
                    else if (feed_reg == '0)
                    begin
                        ival_reg[axis_reg] <= IV_MAX;
                        axis_reg           <= axis_reg + 1'b1;
                    end
                end
                ST_IV_DIV:
                begin
                    if (div_done)
                    begin
                        ival_reg[axis_reg] <= iv_sat;
                        axis_reg           <= axis_reg + 1'b1;
                    end
                end
                default:
                begin
                    axis_reg <= axis_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && accept_ok)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                d_reg[i] <= d_new[i];
            end
        end
        if (state_reg == ST_MUL)
        begin
            sq_reg[0] <= (2*POS_W)'(d_reg[0]) * (2*POS_W)'(d_reg[0]);
            sq_reg[1] <= (2*POS_W)'(d_reg[1]) * (2*POS_W)'(d_reg[1]);
        end
        if ((state_reg == ST_SQRT) && sqrt_done)
        begin
            if ((d_reg[0] != '0) || (d_reg[1] != '0))
            begin
                dist_reg <= root;
            end
            else if (d_reg[2] != '0)
            begin
                dist_reg <= DIST_W'(d_reg[2]);
            end
            else
            begin
                dist_reg <= DIST_W'(d_reg[3]);
            end
        end
        if (state_reg == ST_DUR_MUL)
        begin
            dur_reg <= DUR_W'(dist_reg) * DUR_W'(USEC_PER_MIN);
        end
        if ((state_reg == ST_DUR_DIV) && div_done)
        begin
            dur_reg <= div_q;
        end
    end

    fspp_isqrt #(
        .IN_W (ROOT_IN_W)
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (ROOT_IN_W'(sq_reg[0]) + ROOT_IN_W'(sq_reg[1])),
        .done    (sqrt_done),
        .root    (root)
    );

    fspp_div #(
        .DVD_W (DUR_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dur_reg),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

// ===== design/four_axis_step_pulse_planner.sv =====
// ============================================================================
// four_axis_step_pulse_planner: four-axis stepper step rate generator
// Keeps X, Y, Z and extruder positions, plans moves and emits step pulses.
// ============================================================================
// Every input beat produces exactly one output beat, in order. A tick, a
// set-position, a rejected request or an unknown request is finished as
// soon as it reaches the head of the two-beat input queue, no move is
// being planned and the output register is free. An accepted move runs
// four step-count multiplies, a square root for the XY path length, then
// up to five divisions on one shared one-bit-per-cycle divider (duration
// from feedrate, then one step interval per axis with steps). That divider
// sets the move latency. The queue keeps taking beats, until both entries
// are full, while a move is planned or while a result waits on the output.
// Positions are in 1/2^POS_FRAC_BITS mm, step intervals and elapsed times
// in microseconds, saturated at INTERVAL_WIDTH bits. Configuration writes
// are accepted at any time and should only be issued while the block is idle.
module four_axis_step_pulse_planner
    import fspp_pkg::*;
#(
    parameter int POS_FRAC_BITS  = 8,
    parameter int INTERVAL_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: target_x[23:0], target_y, target_z, target_e,
    // axis_present[3:0], feed_mm_per_min[15:0], feed_present, 3 zero bits.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[1:0].
    input  logic [REQ_W-1:0]      s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: step_x, step_y, step_z, step_e, dir_x, dir_y,
    // dir_z, dir_e, moving, move_done, rejected, 5 zero bits.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SPM_W-1:0]      cfg_data
);

    fspp_cfg_t        cfg_reg;
    fspp_item_t       head_item;
    logic             head_valid;
    logic             pop;
    logic [RES_W-1:0] res_data;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spm[0]         <= SPM_X_RESET;
            cfg_reg.spm[1]         <= SPM_Y_RESET;
            cfg_reg.spm[2]         <= SPM_Z_RESET;
            cfg_reg.spm[3]         <= SPM_E_RESET;
            cfg_reg.forbid_retract <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPM_X:  cfg_reg.spm[0]         <= cfg_data;
                CFG_SPM_Y:  cfg_reg.spm[1]         <= cfg_data;
                CFG_SPM_Z:  cfg_reg.spm[2]         <= cfg_data;
                CFG_SPM_E:  cfg_reg.spm[3]         <= cfg_data;
                CFG_FORBID: cfg_reg.forbid_retract <= cfg_data[0];
                default:    cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front end: accept and classify beats into a short queue.
    fspp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // Back end: axis state, move planning and the output register.
    fspp_back #(
        .POS_FRAC_BITS  (POS_FRAC_BITS),
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_data   (res_data)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, res_data};

endmodule

// ===== design/fspp_checker.sv =====
// ============================================================================
// fspp_checker: port-level checks for the step pulse planner
// Watches the output stream and flags inconsistent result beats.
// ============================================================================
module fspp_checker
    import fspp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [REQ_W-1:0]      s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [SPM_W-1:0]      cfg_data
);

    // A finished move leaves nothing still moving.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> !m_axis_tdata[8])
        else $error("move_done reported while still moving");

    // The last step of a move is a step.
    a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> (m_axis_tdata[3:0] != 4'b0000))
        else $error("move_done without a step pulse");

    // A rejected request never steps and only happens while moving.
    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10] |->
            (m_axis_tdata[3:0] == 4'b0000) && m_axis_tdata[8] && !m_axis_tdata[9])
        else $error("rejected beat is inconsistent");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

endmodule

bind four_axis_step_pulse_planner fspp_checker u_fspp_checker (.*);
